// ===== rtl/abln_pkg.sv =====
package abln_pkg;

    localparam int BANDS = 7;
    localparam int BAND_W = 3;
    localparam int LVL_W = 17;
    localparam int Q_W = 16;
    localparam int CFG_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CNT_W = $clog2(Q_W + 1);

    localparam logic [BAND_W-1:0] BAND_LAST = BAND_W'(BANDS - 1);

    localparam logic signed [LVL_W-1:0] FLOOR_RESET = -17'sd23040;
    localparam logic signed [LVL_W-1:0] PEAK_RESET = -17'sd8960;

    localparam logic [CFG_W-1:0] FLOOR_RISE_RESET = 16'd1;
    localparam logic [CFG_W-1:0] PEAK_FALL_RESET = 16'd6;
    localparam logic [CFG_W-1:0] MIN_SPAN_RESET = 16'd5120;
    localparam logic [CFG_W-1:0] ATTACK_RESET = 16'd27930;
    localparam logic [CFG_W-1:0] RELEASE_RESET = 16'd3540;

    localparam logic [CFG_IDX_W-1:0] REG_FLOOR_RISE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_FALL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SPAN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 3'd4;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

// ===== rtl/abln_div.sv =====
module abln_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [abln_pkg::LVL_W-1:0]  num,
    input  logic [abln_pkg::LVL_W-1:0]  den,
    output logic [abln_pkg::Q_W-1:0]    quo,
    output abln_pkg::unit_stat_t        stat
);

    logic [abln_pkg::LVL_W-1:0] rem_reg;
    logic [abln_pkg::LVL_W-1:0] den_reg;
    logic [abln_pkg::Q_W-1:0]   quo_reg;
    logic [abln_pkg::CNT_W-1:0] cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;

    logic [abln_pkg::LVL_W:0]   rem_sh;
    logic [abln_pkg::LVL_W:0]   trial;
    logic                       fits;
    logic [abln_pkg::LVL_W-1:0] rem_next;

    // One quotient bit per cycle; the remainder always stays below the divisor.
    assign rem_sh   = {rem_reg, 1'b0};
    assign trial    = rem_sh - {1'b0, den_reg};
    assign fits     = !trial[abln_pkg::LVL_W];
    assign rem_next = fits ? trial[abln_pkg::LVL_W-1:0] : rem_sh[abln_pkg::LVL_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                // A quotient of one or more saturates, so no iteration is needed.
                priority if (den == '0)
                begin
                    quo_reg  <= (num != '0) ? '1 : '0;
                    done_reg <= 1'b1;
                end
                else if (num >= den)
                begin
                    quo_reg  <= '1;
                    done_reg <= 1'b1;
                end
                else
                begin
                    rem_reg  <= num;
                    den_reg  <= den;
                    quo_reg  <= '0;
                    cnt_reg  <= abln_pkg::CNT_W'(abln_pkg::Q_W);
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[abln_pkg::Q_W-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == abln_pkg::CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quo       = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== rtl/abln_mul.sv =====
module abln_mul (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [abln_pkg::Q_W-1:0]  mcand,
    input  logic [abln_pkg::Q_W-1:0]  mplr,
    output logic [abln_pkg::Q_W-1:0]  prod_hi,
    output abln_pkg::unit_stat_t      stat
);

    logic [abln_pkg::Q_W-1:0]   a_reg;
    logic [abln_pkg::Q_W-1:0]   hi_reg;
    logic [abln_pkg::Q_W-1:0]   lo_reg;
    logic [abln_pkg::CNT_W-1:0] cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;

    logic [abln_pkg::Q_W:0]     sum;

    // Shift-add over the multiplier bits, low bit first; only the upper half is kept.
    assign sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                a_reg    <= mcand;
                lo_reg   <= mplr;
                hi_reg   <= '0;
                cnt_reg  <= abln_pkg::CNT_W'(abln_pkg::Q_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                hi_reg  <= sum[abln_pkg::Q_W:1];
                lo_reg  <= lo_reg >> 1;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == abln_pkg::CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign prod_hi   = hi_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== rtl/adaptive_band_level_normalizer.sv =====
// Channel  Dir  Handshake        Payload
// s_*      in   tvalid/tready    tuser: band; tdata: level_db
// m_*      out  tvalid/tready    tuser: band_out; tdata: normalized, smoothed
// cfg_*    in   cfg_we           cfg_addr selects the register, cfg_wdata the value
//
// An item in range goes through the floor, peak and span states, the bit-serial divider (no
// iteration when the quotient saturates), the difference state, the bit-serial multiplier and
// the load of the output register, which waits while an earlier result is still unaccepted.
// The next item is accepted only after the result is loaded.
// An item with a band out of range skips to the output load and changes no state.
// Reset sets every band's floor, peak and smoothed level at once; there is no sweep.
// A waiting result holds in the output register while the next item is accepted.
module adaptive_band_level_normalizer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [23:0]                       s_tdata,   // [16:0] level_db
    input  logic [abln_pkg::BAND_W-1:0]       s_tuser,   // [2:0] band
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [31:0]                       m_tdata,   // [15:0] normalized, [31:16] smoothed
    output logic [abln_pkg::BAND_W-1:0]       m_tuser,   // [2:0] band_out
    input  logic                              cfg_we,
    input  logic [abln_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [abln_pkg::CFG_W-1:0]        cfg_wdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FLOOR,
        S_PEAK,
        S_SPAN,
        S_DIV,
        S_DIFF,
        S_MUL,
        S_OUT
    } state_t;

    typedef logic signed [abln_pkg::LVL_W-1:0] lvl_t;
    typedef logic signed [abln_pkg::LVL_W:0]   lvl_wide_t;

    state_t state_reg;

    logic [abln_pkg::CFG_W-1:0] rise_reg;
    logic [abln_pkg::CFG_W-1:0] fall_reg;
    logic [abln_pkg::CFG_W-1:0] span_reg;
    logic [abln_pkg::CFG_W-1:0] attack_reg;
    logic [abln_pkg::CFG_W-1:0] release_reg;

    lvl_t                     floor_mem [abln_pkg::BANDS];
    lvl_t                     peak_mem  [abln_pkg::BANDS];
    logic [abln_pkg::Q_W-1:0] smooth_mem[abln_pkg::BANDS];

    logic [abln_pkg::BAND_W-1:0] band_reg;
    lvl_t                        level_reg;
    lvl_t                        fl_reg;
    lvl_t                        pk_reg;
    logic [abln_pkg::Q_W-1:0]    norm_reg;
    logic                        up_reg;
    logic [abln_pkg::Q_W-1:0]    res_norm_reg;
    logic [abln_pkg::Q_W-1:0]    res_smooth_reg;

    logic                        m_tvalid_reg;
    logic [abln_pkg::BAND_W-1:0] m_band_reg;
    logic [abln_pkg::Q_W-1:0]    m_norm_reg;
    logic [abln_pkg::Q_W-1:0]    m_smooth_reg;

    // Floor step
    lvl_t      fl_cur;
    lvl_wide_t gap;
    lvl_wide_t fl_sum;
    lvl_t      fl_next;

    // Peak step
    lvl_t      pk_cur;
    lvl_wide_t pk_dec;
    lvl_wide_t pk_cand;
    lvl_wide_t pk_lo;
    lvl_wide_t pk_max;
    lvl_t      pk_next;

    // Span and smoothing
    lvl_wide_t                num_wide;
    lvl_wide_t                den_wide;
    logic [abln_pkg::Q_W-1:0] prev_smooth;
    logic                     up_now;
    logic [abln_pkg::Q_W-1:0] diff_now;
    logic [abln_pkg::Q_W-1:0] smooth_next;

    logic                     div_start;
    logic [abln_pkg::Q_W-1:0] div_quo;
    abln_pkg::unit_stat_t     div_stat;
    logic                     mul_start;
    logic [abln_pkg::Q_W-1:0] mul_hi;
    abln_pkg::unit_stat_t     mul_stat;

    logic band_bad;

    assign band_bad = band_reg > abln_pkg::BAND_LAST;

    always_comb
    begin
        fl_cur  = floor_mem[band_reg];
        gap     = lvl_wide_t'(level_reg) - lvl_wide_t'(fl_cur);
        fl_sum  = lvl_wide_t'(fl_cur) + $signed({2'b00, rise_reg});
        // A rise larger than the gap lands exactly on the level.
        fl_next = ((level_reg < fl_cur) || (gap < $signed({2'b00, rise_reg})))
                  ? level_reg : fl_sum[abln_pkg::LVL_W-1:0];
    end

    always_comb
    begin
        pk_cur  = peak_mem[band_reg];
        pk_dec  = lvl_wide_t'(pk_cur) - $signed({2'b00, fall_reg});
        pk_cand = (level_reg > pk_cur) ? lvl_wide_t'(level_reg) : pk_dec;
        pk_lo   = lvl_wide_t'(fl_reg) + $signed({2'b00, span_reg});
        pk_max  = (pk_cand < pk_lo) ? pk_lo : pk_cand;
        // The lower bound already keeps the peak at or above the 17-bit minimum.
        pk_next = (pk_max > lvl_wide_t'(18'sd65535)) ? 17'sd65535
                                                     : pk_max[abln_pkg::LVL_W-1:0];
    end

    always_comb
    begin
        num_wide    = lvl_wide_t'(level_reg) - lvl_wide_t'(fl_reg);
        den_wide    = lvl_wide_t'(pk_reg) - lvl_wide_t'(fl_reg);
        prev_smooth = smooth_mem[band_reg];
        up_now      = norm_reg > prev_smooth;
        diff_now    = up_now ? (norm_reg - prev_smooth) : (prev_smooth - norm_reg);
        smooth_next = up_reg ? (prev_smooth + mul_hi) : (prev_smooth - mul_hi);
    end

    assign div_start = (state_reg == S_SPAN);
    assign mul_start = (state_reg == S_DIFF);

    abln_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_wide[abln_pkg::LVL_W-1:0]),
        .den   (den_wide[abln_pkg::LVL_W-1:0]),
        .quo   (div_quo),
        .stat  (div_stat)
    );

    abln_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (diff_now),
        .mplr    (up_now ? attack_reg : release_reg),
        .prod_hi (mul_hi),
        .stat    (mul_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rise_reg    <= abln_pkg::FLOOR_RISE_RESET;
            fall_reg    <= abln_pkg::PEAK_FALL_RESET;
            span_reg    <= abln_pkg::MIN_SPAN_RESET;
            attack_reg  <= abln_pkg::ATTACK_RESET;
            release_reg <= abln_pkg::RELEASE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                abln_pkg::REG_FLOOR_RISE: rise_reg    <= cfg_wdata;
                abln_pkg::REG_PEAK_FALL:  fall_reg    <= cfg_wdata;
                abln_pkg::REG_MIN_SPAN:   span_reg    <= cfg_wdata;
                abln_pkg::REG_ATTACK:     attack_reg  <= cfg_wdata;
                abln_pkg::REG_RELEASE:    release_reg <= cfg_wdata;
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < abln_pkg::BANDS; i++)
            begin
                floor_mem[i]  <= abln_pkg::FLOOR_RESET;
                peak_mem[i]   <= abln_pkg::PEAK_RESET;
                smooth_mem[i] <= '0;
            end
        end
        else
        begin
            // In S_OUT the output register is handled by the state itself.
            if (m_tvalid_reg && m_tready && (state_reg != S_OUT))
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        band_reg  <= s_tuser;
                        level_reg <= s_tdata[abln_pkg::LVL_W-1:0];
                        state_reg <= S_FLOOR;
                    end
                end
                S_FLOOR:
                begin
                    if (band_bad)
                    begin
                        res_norm_reg   <= '0;
                        res_smooth_reg <= '0;
                        state_reg      <= S_OUT;
                    end
                    else
                    begin
                        fl_reg    <= fl_next;
                        state_reg <= S_PEAK;
                    end
                end
                S_PEAK:
                begin
                    pk_reg              <= pk_next;
                    floor_mem[band_reg] <= fl_reg;
                    peak_mem[band_reg]  <= pk_next;
                    state_reg           <= S_SPAN;
                end
                S_SPAN:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_stat.done)
                    begin
                        norm_reg  <= div_quo;
                        state_reg <= S_DIFF;
                    end
                end
                S_DIFF:
                begin
                    up_reg    <= up_now;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    if (mul_stat.done)
                    begin
                        smooth_mem[band_reg] <= smooth_next;
                        res_norm_reg         <= norm_reg;
                        res_smooth_reg       <= smooth_next;
                        state_reg            <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_band_reg   <= band_reg;
                        m_norm_reg   <= res_norm_reg;
                        m_smooth_reg <= res_smooth_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_band_reg;
    assign m_tdata  = {m_smooth_reg, m_norm_reg};

    // A band out of range reports zero level fields.
    a_bad_band_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser > abln_pkg::BAND_LAST)) |-> (m_tdata == '0))
        else $error("out-of-range band returned nonzero fields");

    // The span fed to the divider is never negative.
    a_peak_above_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SPAN) |-> (pk_reg >= fl_reg))
        else $error("peak below floor");

    a_div_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_mul_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mul_start |-> !mul_stat.busy)
        else $error("multiplier started while busy");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == S_FLOOR))
        else $error("accepted transaction did not start processing");

endmodule

// ===== test/adaptive_band_level_normalizer_tb.sv =====
module adaptive_band_level_normalizer_tb;
    import abln_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int HOLD_AT_RESULT = 300;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS = 240;
    localparam longint LVL_LO = -65536;
    localparam longint LVL_HI = 65535;
    localparam longint DB_LO = -46080;
    localparam longint DB_HI = 5120;

    typedef struct packed {
        logic [BAND_W-1:0]       band;
        logic signed [LVL_W-1:0] level;
    } level_item_t;

    typedef struct packed {
        logic [BAND_W-1:0] band;
        logic [Q_W-1:0]    norm;
        logic [Q_W-1:0]    smooth;
    } band_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [23:0]          s_tdata = '0;   // [16:0] level_db
    logic [BAND_W-1:0]    s_tuser = '0;   // [2:0] band
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [31:0]          m_tdata;        // [15:0] normalized, [31:16] smoothed
    logic [BAND_W-1:0]    m_tuser;        // [2:0] band_out
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    adaptive_band_level_normalizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // Shadow copy of the register file and the per-band tracking state.
    longint cfg_rise, cfg_fall, cfg_span, cfg_attack, cfg_release;
    longint band_floor [BANDS];
    longint band_peak [BANDS];
    longint band_smooth [BANDS];
    longint walk_level [BANDS];

    level_item_t  level_items_q [$];
    band_result_t norm_expect_q [$];

    int  items_queued = 0;
    int  items_taken = 0;
    int  results_seen = 0;
    int  errors = 0;
    int  idle_cycles = 0;
    int  src_gap_left = 0;
    int  snk_stall_left = 0;
    int  hold_left = 0;
    bit  long_hold_done = 1'b0;
    bit  src_gaps_on = 1'b1;
    bit  snk_stalls_on = 1'b1;

    level_item_t  nxt;
    band_result_t pred;
    band_result_t want;

    function automatic void reset_tracking();
        cfg_rise = FLOOR_RISE_RESET;
        cfg_fall = PEAK_FALL_RESET;
        cfg_span = MIN_SPAN_RESET;
        cfg_attack = ATTACK_RESET;
        cfg_release = RELEASE_RESET;
        for (int b = 0; b < BANDS; b++)
        begin
            band_floor[b] = FLOOR_RESET;
            band_peak[b] = PEAK_RESET;
            band_smooth[b] = 0;
            walk_level[b] = -20000;
        end
    endfunction

    // Updates an in-range band's floor, peak, smoothed level; returns the result.
    function automatic band_result_t normalize_level(logic [BAND_W-1:0] band,
                                                     logic signed [LVL_W-1:0] level_in);
        band_result_t r;
        longint lvl, fl, pk, num, den, q, prev, step;
        r.band = band;
        r.norm = '0;
        r.smooth = '0;
        if (band >= BANDS)
            return r;
        lvl = level_in;
        fl = band_floor[band];
        if (lvl < fl)
            fl = lvl;
        else
            fl += ((lvl - fl) < cfg_rise) ? (lvl - fl) : cfg_rise;
        pk = band_peak[band];
        if (lvl > pk)
            pk = lvl;
        else
            pk -= cfg_fall;
        if (pk < fl + cfg_span)
            pk = fl + cfg_span;
        if (pk > LVL_HI)
            pk = LVL_HI;
        if (pk < LVL_LO)
            pk = LVL_LO;
        band_floor[band] = fl;
        band_peak[band] = pk;
        num = lvl - fl;
        den = pk - fl;
        if (den <= 0)
            q = (num > 0) ? 65535 : 0;
        else
        begin
            q = (num << 16) / den;
            if (q > 65535)
                q = 65535;
        end
        prev = band_smooth[band];
        if (q > prev)
        begin
            step = ((q - prev) * cfg_attack) >> 16;
            prev += step;
        end
        else
        begin
            step = ((prev - q) * cfg_release) >> 16;
            prev -= step;
        end
        band_smooth[band] = prev;
        r.norm = q[Q_W-1:0];
        r.smooth = prev[Q_W-1:0];
        return r;
    endfunction

    // Mostly no gap, sometimes a short one, rarely a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [CFG_W-1:0] pick_cfg();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return CFG_W'($urandom_range(1, 64));
            3, 4: return CFG_W'($urandom_range(256, 8192));
            default: return CFG_W'($urandom);
        endcase
    endfunction

    task automatic queue_item(input logic [BAND_W-1:0] band, input logic signed [LVL_W-1:0] level);
        level_item_t it;
        it.band = band;
        it.level = level;
        level_items_q = {level_items_q, it};
        items_queued++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_FLOOR_RISE: cfg_rise = val;
            REG_PEAK_FALL:  cfg_fall = val;
            REG_MIN_SPAN:   cfg_span = val;
            REG_ATTACK:     cfg_attack = val;
            REG_RELEASE:    cfg_release = val;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (items_taken != items_queued || norm_expect_q.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Most items follow a slow random walk per band so that floor and peak
    // adapt as on real audio; others are noise, out-of-range bands, edge values.
    task automatic random_item();
        int r;
        int b;
        r = $urandom_range(0, 99);
        b = $urandom_range(0, BANDS - 1);
        if (r < 70)
        begin
            if ($urandom_range(0, 19) == 0)
                walk_level[b] = $urandom_range(0, DB_HI - DB_LO) + DB_LO;
            else
                walk_level[b] += longint'($urandom_range(0, 2048)) - 1024;
            if (walk_level[b] < DB_LO)
                walk_level[b] = DB_LO;
            if (walk_level[b] > DB_HI)
                walk_level[b] = DB_HI;
            queue_item(BAND_W'(b), LVL_W'(walk_level[b]));
        end
        else if (r < 80)
            queue_item(BAND_W'(b), LVL_W'($urandom));
        else if (r < 88)
            queue_item(BAND_W'(BANDS + $urandom_range(0, (1 << BAND_W) - 1 - BANDS)),
                       LVL_W'($urandom));
        else
        begin
            case ($urandom_range(0, 3))
                0: queue_item(BAND_W'(b), LVL_W'(LVL_LO));
                1: queue_item(BAND_W'(b), LVL_W'(LVL_HI));
                2: queue_item(BAND_W'(b), LVL_W'(DB_LO));
                default: queue_item(BAND_W'(b), LVL_W'(DB_HI));
            endcase
        end
    endtask

    // Sender: offers queued items, predicting each one as it is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                pred = normalize_level(s_tuser, s_tdata[LVL_W-1:0]);
                norm_expect_q = {norm_expect_q, pred};
                items_taken++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (src_gap_left > 0)
                begin
                    src_gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (level_items_q.size() > 0)
                begin
                    nxt = level_items_q[0];
                    level_items_q.delete(0);
                    s_tvalid <= 1'b1;
                    s_tuser <= nxt.band;
                    s_tdata <= {7'd0, nxt.level};
                    if (src_gaps_on)
                        src_gap_left = gap_len();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: checks each transaction against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (norm_expect_q.size() == 0)
                begin
                    $display("%0t: unexpected result band %0d tdata %h", $time, m_tuser, m_tdata);
                    errors++;
                end
                else
                begin
                    want = norm_expect_q[0];
                    norm_expect_q.delete(0);
                    if (m_tuser !== want.band)
                    begin
                        $display("%0t: band_out expected %0d actual %0d",
                                 $time, want.band, m_tuser);
                        errors++;
                    end
                    if (m_tdata[15:0] !== want.norm)
                    begin
                        $display("%0t: normalized expected %0d actual %0d (band %0d)",
                                 $time, want.norm, m_tdata[15:0], want.band);
                        errors++;
                    end
                    if (m_tdata[31:16] !== want.smooth)
                    begin
                        $display("%0t: smoothed expected %0d actual %0d (band %0d)",
                                 $time, want.smooth, m_tdata[31:16], want.band);
                        errors++;
                    end
                end
            end
            // One long hold-off so the block backs up while items keep coming.
            if (results_seen == HOLD_AT_RESULT && !long_hold_done)
            begin
                long_hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (snk_stall_left > 0)
            begin
                snk_stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (snk_stalls_on)
                    snk_stall_left = gap_len();
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == IDLE_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
                $display("[adaptive_band_level_normalizer] ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        int ph;
        int i;
        reset_tracking();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Default settings: floor and peak jumps, level on the floor and on the
        // peak, sign boundary, field extremes and bands out of range.
        queue_item(3'd0, -17'sd46080);
        queue_item(3'd0, 17'sd5120);
        queue_item(3'd0, 17'sd5120);
        queue_item(3'd1, -17'sd23040);
        queue_item(3'd1, -17'sd8960);
        queue_item(3'd2, 17'sd0);
        queue_item(3'd2, -17'sd1);
        queue_item(BAND_LAST, 17'sd65535);
        queue_item(BAND_LAST, -17'sd65536);
        queue_item(3'd7, 17'sd100);
        queue_item(3'd7, -17'sd65536);
        queue_item(3'd5, -17'sd12000);
        queue_item(3'd5, -17'sd12000);
        wait_drained();

        // Floor frozen and no minimum span: the peak collapses onto the floor,
        // giving a zero span with the level on and above the floor.
        write_reg(REG_FLOOR_RISE, '0);
        write_reg(REG_PEAK_FALL, '1);
        write_reg(REG_MIN_SPAN, '0);
        write_reg(REG_ATTACK, '1);
        write_reg(REG_RELEASE, '0);
        write_reg(CFG_IDX_W'(REG_RELEASE + 1), 16'hA5A5);
        write_reg(CFG_IDX_W'(REG_RELEASE + 2), 16'h5A5A);
        write_reg(CFG_IDX_W'((1 << CFG_IDX_W) - 1), '1);
        queue_item(3'd4, -17'sd30000);
        queue_item(3'd4, -17'sd20000);
        queue_item(3'd4, -17'sd25000);
        wait_drained();

        // Full-speed floor rise and the widest span: the peak saturates at the
        // top of the level range, down to a zero span at the very top.
        write_reg(REG_FLOOR_RISE, '1);
        write_reg(REG_PEAK_FALL, '0);
        write_reg(REG_MIN_SPAN, '1);
        write_reg(REG_ATTACK, '0);
        write_reg(REG_RELEASE, '1);
        queue_item(3'd3, 17'sd60000);
        queue_item(3'd3, 17'sd65535);
        queue_item(3'd3, 17'sd65535);
        queue_item(3'd2, -17'sd65536);
        queue_item(3'd2, 17'sd65535);
        wait_drained();

        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            src_gaps_on = (ph != 0) && ($urandom_range(0, 3) != 0);
            snk_stalls_on = (ph != 0) && ($urandom_range(0, 3) != 0);
            if (ph == 0)
            begin
                write_reg(REG_FLOOR_RISE, FLOOR_RISE_RESET);
                write_reg(REG_PEAK_FALL, PEAK_FALL_RESET);
                write_reg(REG_MIN_SPAN, MIN_SPAN_RESET);
                write_reg(REG_ATTACK, ATTACK_RESET);
                write_reg(REG_RELEASE, RELEASE_RESET);
            end
            else
            begin
                if ($urandom_range(0, 4) < 3)
                    write_reg(REG_FLOOR_RISE, pick_cfg());
                if ($urandom_range(0, 4) < 3)
                    write_reg(REG_PEAK_FALL, pick_cfg());
                if ($urandom_range(0, 4) < 3)
                    write_reg(REG_MIN_SPAN, pick_cfg());
                if ($urandom_range(0, 4) < 3)
                    write_reg(REG_ATTACK, pick_cfg());
                if ($urandom_range(0, 4) < 3)
                    write_reg(REG_RELEASE, pick_cfg());
                if ($urandom_range(0, 3) == 0)
                    write_reg(CFG_IDX_W'($urandom_range(REG_RELEASE + 1, (1 << CFG_IDX_W) - 1)),
                              CFG_W'($urandom));
            end
            for (i = 0; i < PHASE_ITEMS; i++)
                random_item();
            wait_drained();
        end

        repeat (40) @(posedge clk);
        if (errors == 0 && norm_expect_q.size() == 0)
            $display("[adaptive_band_level_normalizer] OK");
        else
            $display("[adaptive_band_level_normalizer] ERROR");
        $finish;
    end

endmodule
